// ----- src/ils_pkg.sv -----
// Package for the indexed LIFO stack: sizes, request/response types, codes.
// No dependencies; used by ils_ctrl, ils_dp and indexed_lifo_stack.
`timescale 1ns / 1ps

package ils_pkg;

  localparam int DEPTH   = 8;
  localparam int VALUE_W = 32;
  localparam int DEPTH_W = 4;
  localparam int FILL_W  = 4;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_CHANGE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_DEPTH = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [VALUE_W-1:0] value;
    logic [DEPTH_W-1:0]        depth;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] data;
    status_t                   status;
    logic [FILL_W-1:0]         fill_count;
  } out_rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ils_cmd_t;

endpackage

// ----- src/ils_ctrl.sv -----
// Controller FSM for the indexed LIFO stack: request handshake and sequencing.
// Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ils_pkg::ils_cmd_t cmd
);
  import ils_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait until the output register is free or being taken
        if (!out_valid_r || !out_stall) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted request did not enter execute");

  a_exec_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (state_r == S_LOAD))
    else $error("execute not followed by load");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid)
    else $error("load did not raise out_valid");

  a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && out_valid_r && out_stall) |=> (state_r == S_LOAD))
    else $error("result overwritten while output stalled");
`endif

endmodule

// ----- src/ils_dp.sv -----
// Datapath for the indexed LIFO stack: request register, entry store, count,
// status decode and output register. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ils_pkg::ils_cmd_t cmd,
  input  ils_pkg::in_req_t  in_req,
  output ils_pkg::out_rsp_t out_rsp
);
  import ils_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  in_req_t            req_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [VALUE_W-1:0] rd_data_r;
  status_t            res_status_r;
  logic               res_rd_r;
  out_rsp_t           out_rsp_r;

  status_t            st;
  logic               we;
  logic               rd_ok;
  logic [ADDR_W-1:0]  addr;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   dep_ext;

  always_comb begin
    cnt_ext   = CMP_W'(count_r);
    dep_ext   = CMP_W'(req_r.depth);
    st        = ST_OK;
    we        = 1'b0;
    rd_ok     = 1'b0;
    count_nxt = count_r;
    addr      = ADDR_W'(cnt_ext - dep_ext);
    case (req_r.mode)
      MODE_PUSH: begin
        if (count_r >= CNT_W'(DEPTH)) begin
          st = ST_FULL;
        end else begin
          we        = 1'b1;
          addr      = ADDR_W'(count_r);
          count_nxt = count_r + 1'b1;
        end
      end
      default: begin
        if (count_r == '0) begin
          st = ST_EMPTY;
        end else if (req_r.mode == MODE_POP) begin
          addr      = ADDR_W'(count_r - 1'b1);
          count_nxt = count_r - 1'b1;
          rd_ok     = 1'b1;
        end else if (dep_ext == '0 || dep_ext > cnt_ext) begin
          st = ST_BAD_DEPTH;
        end else if (req_r.mode == MODE_PEEK) begin
          rd_ok = 1'b1;
        end else begin
          we = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
  end

  // entry store with registered read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (we) begin
        mem[addr] <= req_r.value;
      end
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= st;
      res_rd_r     <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_rsp_r.data       <= res_rd_r ? rd_data_r : '0;
      out_rsp_r.status     <= res_status_r;
      out_rsp_r.fill_count <= FILL_W'(count_r);
    end
  end

  assign out_rsp = out_rsp_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && req_r.mode == MODE_PUSH && st == ST_OK)
      |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted push did not grow the stack");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && st != ST_OK) |=> (count_r == $past(count_r)))
    else $error("refused request changed the count");
`endif

endmodule

// ----- src/indexed_lifo_stack.sv -----
// Top level of the indexed LIFO stack: controller plus datapath.
// Depends on ils_pkg, ils_ctrl and ils_dp.
`timescale 1ns / 1ps

// A stack of DEPTH (8) signed 32-bit words with push, pop, peek at depth and
// change at depth (depth 1 is the top). Every request returns one response
// with the popped or peeked word (zero otherwise), a status (ok, full, empty,
// bad depth) and the fill count after the request; refused requests change
// nothing. A request passes through accept, an execute step that reads or
// writes the entry store at a single address and updates the count, and a
// load step that moves the registered read into the output register once it
// is free. in_stall is low only between requests, so no request is taken
// until the last one is loaded. The response sits in an output register, so
// a new request is accepted while the previous response still waits behind
// out_stall. Only written entries are returned, so no reset clear is needed.
module indexed_lifo_stack (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ils_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output ils_pkg::out_rsp_t out_rsp
);
  import ils_pkg::*;

  ils_cmd_t cmd;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ils_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

endmodule

// ----- bench/tb.sv -----
// Testbench for indexed_lifo_stack: clocked driver and monitor, with a scoreboard
// that predicts every response. Depends on ils_pkg and the indexed_lifo_stack RTL.
`timescale 1ns / 1ps

module tb;
  import ils_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_rsp;

  indexed_lifo_stack DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  // Pending requests, and responses expected in order.
  in_req_t  req_backlog[$];
  out_rsp_t rsp_expected[$];

  // Shadow copy of the stack, advanced on every accepted request.
  logic signed [VALUE_W-1:0] shadow_mem[DEPTH];
  int held;

  // Idle control, set per phase.
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  long_hold_req;
  bit  long_hold_done;
  int  hold_left;

  bit  req_taken;
  int  fail_cnt;
  int  n_reqs;
  int  n_rsps;
  int  n_blocked;
  int  status_tally[4];

  // Generator state: rough fill level so depths mostly land on held entries.
  int  gen_fill;
  int  gen_run_left;
  int  gen_bias;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_rsp_t predict_stack(in_req_t r);
    out_rsp_t o;
    int slot;
    o.data       = '0;
    o.status     = ST_OK;
    if (r.mode == MODE_PUSH) begin
      if (held >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        shadow_mem[held] = r.value;
        held++;
      end
    end else if (held == 0) begin
      o.status = ST_EMPTY;
    end else if (r.mode == MODE_POP) begin
      held--;
      o.data = shadow_mem[held];
    end else if (r.depth == 0 || int'(r.depth) > held) begin
      o.status = ST_BAD_DEPTH;
    end else begin
      slot = held - int'(r.depth);
      if (r.mode == MODE_PEEK) o.data = shadow_mem[slot];
      else shadow_mem[slot] = r.value;
    end
    o.fill_count = FILL_W'(held);
    return o;
  endfunction

  task automatic add_req(input mode_t m, input logic [VALUE_W-1:0] v,
                         input logic [DEPTH_W-1:0] d);
    in_req_t r;
    r.mode  = m;
    r.value = v;
    r.depth = d;
    req_backlog.push_back(r);
    if (m == MODE_PUSH && gen_fill < DEPTH) gen_fill++;
    if (m == MODE_POP && gen_fill > 0) gen_fill--;
  endtask

  task automatic queue_directed();
    add_req(MODE_POP, 32'h0, 4'd0);            // empty stack, all three
    add_req(MODE_PEEK, 32'h0, 4'd1);
    add_req(MODE_CHANGE, 32'h1234_5678, 4'd1);
    add_req(MODE_PUSH, 32'h7FFF_FFFF, 4'd15);  // depth ignored on push
    add_req(MODE_PUSH, 32'h8000_0000, 4'd0);
    add_req(MODE_PUSH, 32'hFFFF_FFFF, 4'd0);
    add_req(MODE_PUSH, 32'h0000_0000, 4'd0);
    add_req(MODE_PUSH, 32'h0000_0001, 4'd0);
    add_req(MODE_PUSH, 32'hA5A5_A5A5, 4'd0);
    add_req(MODE_PUSH, 32'h5A5A_5A5A, 4'd0);
    add_req(MODE_PUSH, 32'hDEAD_BEEF, 4'd0);
    add_req(MODE_PUSH, 32'h0BAD_F00D, 4'd0);   // full
    add_req(MODE_PEEK, 32'hFFFF_FFFF, 4'd0);   // depth zero
    add_req(MODE_PEEK, 32'h0, 4'd8);           // bottom
    add_req(MODE_PEEK, 32'h0, 4'd9);           // one past fill
    add_req(MODE_PEEK, 32'h0, 4'd15);
    add_req(MODE_CHANGE, 32'h8000_0000, 4'd1);
    add_req(MODE_CHANGE, 32'h7FFF_FFFF, 4'd8);
    add_req(MODE_CHANGE, 32'h1111_1111, 4'd0);
    add_req(MODE_CHANGE, 32'h2222_2222, 4'd12);
    add_req(MODE_PEEK, 32'h0, 4'd1);
    add_req(MODE_PEEK, 32'h0, 4'd8);
    repeat (DEPTH) add_req(MODE_POP, 32'hFFFF_FFFF, 4'd15);
    add_req(MODE_POP, 32'h0, 4'd0);
  endtask

  task automatic queue_random(input int n);
    int k;
    int roll;
    mode_t m;
    logic [VALUE_W-1:0] v;
    logic [DEPTH_W-1:0] d;
    for (k = 0; k < n; k++) begin
      // Runs of push-heavy, pop-heavy or mixed traffic walk the fill
      // level between empty and full.
      if (gen_run_left == 0) begin
        gen_bias     = $urandom_range(2);
        gen_run_left = $urandom_range(4, 20);
      end
      gen_run_left--;
      roll = $urandom_range(99);
      case (gen_bias)
        0: m = (roll < 55) ? MODE_PUSH : (roll < 65) ? MODE_POP :
               (roll < 83) ? MODE_PEEK : MODE_CHANGE;
        1: m = (roll < 10) ? MODE_PUSH : (roll < 60) ? MODE_POP :
               (roll < 80) ? MODE_PEEK : MODE_CHANGE;
        default: m = mode_t'($urandom_range(3));
      endcase
      roll = $urandom_range(99);
      if (roll < 5) v = 32'h8000_0000;
      else if (roll < 10) v = 32'h7FFF_FFFF;
      else v = $urandom;
      roll = $urandom_range(99);
      if (gen_fill > 0 && roll < 75) d = DEPTH_W'($urandom_range(1, gen_fill));
      else d = DEPTH_W'($urandom_range(15));
      add_req(m, v, d);
    end
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid || rsp_expected.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: new request only once the current one has been taken.
  always @(negedge clk) begin : req_driver
    logic next_valid;
    next_valid = in_valid;
    if (rst_n && (!in_valid || req_taken)) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_req     <= req_backlog.pop_front();
        next_valid = 1'b1;
      end else begin
        next_valid = 1'b0;
      end
    end
    in_valid <= next_valid;
  end

  // Receiver back-pressure; the long hold is counted here.
  always @(negedge clk) begin : rsp_stall_gen
    logic stall_now;
    if (long_hold_req && !long_hold_done) begin
      hold_left      = 120;
      long_hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      stall_now = 1'b1;
      hold_left--;
    end else begin
      stall_now = ($urandom_range(99) < recv_stall_pct);
    end
    out_stall <= stall_now;
  end

  // Monitor: record accepted requests, check responses against the oldest
  // expectation.
  always @(posedge clk) begin : rsp_monitor
    out_rsp_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_rsps++;
      if (rsp_expected.size() == 0) begin
        $error("response with no request outstanding: data %0d status %0d fill %0d",
               out_rsp.data, out_rsp.status, out_rsp.fill_count);
        fail_cnt++;
      end else begin
        want = rsp_expected.pop_front();
        if (out_rsp.data !== want.data) begin
          $error("data: expected %0d, actual %0d", want.data, out_rsp.data);
          fail_cnt++;
        end
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_rsp.status);
          fail_cnt++;
        end
        if (out_rsp.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, actual %0d", want.fill_count,
                 out_rsp.fill_count);
          fail_cnt++;
        end
      end
    end
    req_taken = rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && in_stall) n_blocked++;
    if (req_taken) begin
      want = predict_stack(in_req);
      rsp_expected.push_back(want);
      status_tally[want.status]++;
      n_reqs++;
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = 1'b0;
    long_hold_done = 1'b0;
    hold_left      = 0;
    req_taken      = 1'b0;
    fail_cnt       = 0;
    n_reqs         = 0;
    n_rsps         = 0;
    n_blocked      = 0;
    status_tally   = '{default: 0};
    held           = 0;
    gen_fill       = 0;
    gen_run_left   = 0;
    gen_bias       = 2;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_directed();
    wait_drained();

    queue_random(350);
    wait_drained();

    send_idle_pct = 87;
    queue_random(350);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 87;
    queue_random(350);
    wait_drained();

    send_idle_pct  = 6;
    recv_stall_pct = 6;
    queue_random(350);
    wait_drained();

    // Receiver holds off while the sender keeps offering, so the block
    // fills up and raises in_stall.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = 1'b1;
    queue_random(40);
    wait_drained();

    repeat (12) @(posedge clk);
    if (rsp_expected.size() != 0) begin
      $error("%0d responses never arrived", rsp_expected.size());
      fail_cnt++;
    end

    $display("%0d requests, %0d responses checked, %0d cycles of input back-pressure",
             n_reqs, n_rsps, n_blocked);
    $display("status mix: ok %0d, full %0d, empty %0d, bad depth %0d",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_BAD_DEPTH]);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- indexed_lifo_stack.f -----
src/ils_pkg.sv
src/ils_ctrl.sv
src/ils_dp.sv
src/indexed_lifo_stack.sv
bench/tb.sv
